// ----- hw/rtl/lfsv_pkg.sv -----
package lfsv_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] CAUSE_CLEAN   = 2'd0;
   localparam logic [1:0] CAUSE_PARTIAL = 2'd1;
   localparam logic [1:0] CAUSE_LENGTH  = 2'd2;
   localparam logic [1:0] CAUSE_CRC     = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_log;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] entry_index;
      logic [63:0] entry_term;
      logic [31:0] payload_length;
      logic [47:0] frame_offset;
      logic [47:0] valid_end_offset;
      logic [47:0] record_count;
      logic [1:0]  stop_cause;
      logic        last_of_run;
   } rsp_type;

   // write strobes into the result queue; second is only used with first
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // reflected CRC-32, one byte, bit at a time
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/lfsv_rsp_fifo.sv -----
module lfsv_rsp_fifo
   import lfsv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  rsp_type  push_data0,
   input  rsp_type  push_data1,
   output logic     space_ok,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type    entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   // room for two items, so an item that makes a record and a summary never blocks
   assign space_ok  = (count_ff <= 3'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(push.first) + 2'(push.second);
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(push.first) + 3'(push.second) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push.second) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push_data1;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count out of range");

   a_second_needs_first : assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first)
      else $error("second push without first");

   a_push_has_room : assert property (@(posedge clock) disable iff (reset)
      push.first |-> count_ff <= 3'd2)
      else $error("push into result queue without room");
`endif

endmodule

// ----- hw/rtl/log_frame_scan_validator.sv -----
// Log frame scanner and validator.
// req_* carries one log byte per item (byte_valid 0 gives an end-only item);
// end_of_log marks the last item of a log. Each frame is a length, index,
// term, payload length, payload and CRC-32; every good frame yields a record
// item on rsp_*, and the end of the log yields one summary item with the
// truncate offset, the record count and the stop cause.
// Throughput: one req item per cycle while req_ready is high. The frame state
// and CRC are updated at the accepting edge, so results sit in a four-deep
// result queue in the next cycle. An item can cause two results; req_ready is low
// while the queue holds more than two items, so a stalled receiver fills the
// queue and then holds off the sender, and a steady ready receiver sees no gap.
// After the first bad frame, bytes are dropped until end_of_log; after the
// summary all scan state returns to its reset values for the next log.
// reset (synchronous, active high) clears the scan state and empties the queue.
module log_frame_scan_validator
   import lfsv_pkg::*;
#(
   parameter int OFFSET_WIDTH = 48,
   parameter int INDEX_BYTES  = 8,
   parameter int TERM_BYTES   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW       = INDEX_BYTES * 8;
   localparam int TW       = TERM_BYTES * 8;
   localparam int OW       = OFFSET_WIDTH;
   localparam int TERM_POS = 4 + INDEX_BYTES;
   localparam int PLEN_POS = TERM_POS + TERM_BYTES;
   localparam logic [32:0] HDR_LEN = 33'(INDEX_BYTES + TERM_BYTES + 8);

   logic [32:0]   bif_ff, bif_in;
   logic [31:0]   flen_ff, flen_in;
   logic [31:0]   plen_ff, plen_in;
   logic [31:0]   crc_ff, crc_in;
   logic [31:0]   scrc_ff, scrc_in;
   logic [IW-1:0] index_ff, index_in;
   logic [TW-1:0] term_ff, term_in;
   logic [OW-1:0] fstart_ff, fstart_in;
   logic [47:0]   count_ff, count_in;
   logic          stopped_ff, stopped_in;
   logic [1:0]    reason_ff, reason_in;

   logic          req_fire, take, at_end, crc_sel, judge, len_bad, crc_bad, rec;
   logic [32:0]   q, s;
   logic [31:0]   flen_new, plen_new, crc_new, scrc_new;
   logic [IW-1:0] index_new;
   logic [TW-1:0] term_new;
   logic [OW+1:0] fstart_sum;
   logic [1:0]    cause;
   logic          space_ok;
   push_type      push;
   rsp_type       rsp0, rsp1, rec_rsp, sum_rsp;

   assign req_ready = space_ok;
   assign req_fire  = req_valid && req_ready;
   assign take      = req_fire && req_data.byte_valid && !stopped_ff;
   assign at_end    = req_fire && req_data.end_of_log;

   always_comb begin
      q        = bif_ff + 33'd1;
      crc_sel  = (bif_ff < 33'd4) || (bif_ff < {1'b0, flen_ff});
      s        = bif_ff - {1'b0, flen_ff};
      flen_new  = flen_ff;
      plen_new  = plen_ff;
      index_new = index_ff;
      term_new  = term_ff;
      scrc_new  = scrc_ff;
      crc_new   = crc_ff;
      if (take) begin
         if (crc_sel) begin
            crc_new = crc_byte(crc_ff, req_data.data_byte);
         end else if (s < 33'd4) begin
            scrc_new[8*s[1:0] +: 8] = req_data.data_byte;
         end
         if (bif_ff < 33'd4) begin
            flen_new[8*bif_ff[1:0] +: 8] = req_data.data_byte;
         end
         for (int k = 0; k < INDEX_BYTES; k++) begin
            if (bif_ff == 33'(4 + k)) begin
               index_new[8*k +: 8] = req_data.data_byte;
            end
         end
         for (int k = 0; k < TERM_BYTES; k++) begin
            if (bif_ff == 33'(TERM_POS + k)) begin
               term_new[8*k +: 8] = req_data.data_byte;
            end
         end
         for (int k = 0; k < 4; k++) begin
            if (bif_ff == 33'(PLEN_POS + k)) begin
               plen_new[8*k +: 8] = req_data.data_byte;
            end
         end
      end

      // judge the frame once its last stored-checksum byte is in
      judge   = take && (q >= 33'd4) && (q == {1'b0, flen_new} + 33'd4);
      len_bad = ({1'b0, flen_new} < HDR_LEN) || ({1'b0, flen_new} != HDR_LEN + {1'b0, plen_new});
      crc_bad = (crc_new ^ CRC_ONES) != scrc_new;
      rec     = judge && !len_bad && !crc_bad;

      // frame size can exceed the offset range at the narrowest offset width
      fstart_sum = {2'b00, fstart_ff} + (OW+2)'({1'b0, flen_new} + 33'd4);
      fstart_in  = fstart_ff;
      count_in   = count_ff;
      if (rec) begin
         fstart_in = (|fstart_sum[OW+1:OW]) ? {OW{1'b1}} : fstart_sum[OW-1:0];
         count_in  = (count_ff == {48{1'b1}}) ? count_ff : count_ff + 48'd1;
      end

      stopped_in = stopped_ff;
      reason_in  = reason_ff;
      if (judge && len_bad) begin
         stopped_in = 1'b1;
         reason_in  = CAUSE_LENGTH;
      end else if (judge && crc_bad) begin
         stopped_in = 1'b1;
         reason_in  = CAUSE_CRC;
      end

      bif_in   = take ? q : bif_ff;
      flen_in  = flen_new;
      plen_in  = plen_new;
      index_in = index_new;
      term_in  = term_new;
      scrc_in  = scrc_new;
      crc_in   = crc_new;
      if (rec) begin
         bif_in = '0;
      end

      if (stopped_in) begin
         cause = reason_in;
      end else if (bif_in != 33'd0) begin
         cause = CAUSE_PARTIAL;
      end else begin
         cause = CAUSE_CLEAN;
      end

      rec_rsp.kind             = KIND_RECORD;
      rec_rsp.entry_index      = 64'(index_new);
      rec_rsp.entry_term       = 64'(term_new);
      rec_rsp.payload_length   = plen_new;
      rec_rsp.frame_offset     = 48'(fstart_ff);
      rec_rsp.valid_end_offset = 48'(fstart_in);
      rec_rsp.record_count     = count_in;
      rec_rsp.stop_cause       = CAUSE_CLEAN;
      rec_rsp.last_of_run      = !at_end;

      sum_rsp.kind             = KIND_SUMMARY;
      sum_rsp.entry_index      = '0;
      sum_rsp.entry_term       = '0;
      sum_rsp.payload_length   = '0;
      sum_rsp.frame_offset     = '0;
      sum_rsp.valid_end_offset = 48'(fstart_in);
      sum_rsp.record_count     = count_in;
      sum_rsp.stop_cause       = cause;
      sum_rsp.last_of_run      = 1'b1;

      push.first  = rec || at_end;
      push.second = rec && at_end;
      rsp0        = rec ? rec_rsp : sum_rsp;
      rsp1        = sum_rsp;

      // start a fresh frame after a record or at the end of the log
      if (rec || at_end) begin
         bif_in   = '0;
         flen_in  = '0;
         plen_in  = '0;
         index_in = '0;
         term_in  = '0;
         scrc_in  = '0;
         crc_in   = CRC_ONES;
      end
      if (at_end) begin
         fstart_in  = '0;
         count_in   = '0;
         stopped_in = 1'b0;
         reason_in  = CAUSE_CLEAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bif_ff     <= '0;
         flen_ff    <= '0;
         plen_ff    <= '0;
         crc_ff     <= CRC_ONES;
         scrc_ff    <= '0;
         index_ff   <= '0;
         term_ff    <= '0;
         fstart_ff  <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         reason_ff  <= CAUSE_CLEAN;
      end else begin
         bif_ff     <= bif_in;
         flen_ff    <= flen_in;
         plen_ff    <= plen_in;
         crc_ff     <= crc_in;
         scrc_ff    <= scrc_in;
         index_ff   <= index_in;
         term_ff    <= term_in;
         fstart_ff  <= fstart_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         reason_ff  <= reason_in;
      end
   end

   lfsv_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (rsp0),
      .push_data1 (rsp1),
      .space_ok   (space_ok),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_summary_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_SUMMARY) |-> rsp_data.last_of_run)
      else $error("summary item not marked last");

   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      push.second |-> (rsp0.kind == KIND_RECORD && rsp1.kind == KIND_SUMMARY))
      else $error("record and summary pushed out of order");

   a_no_record_when_stopped : assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !rec)
      else $error("record accepted after the scan stopped");
`endif

endmodule
